// ===== src/bmpf_pkg.sv =====
// shared types and constants for the backlight and motor pwm fade block
package bmpf_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int DUTY_BITS_DEF  = 6;

  localparam int CMD_W    = 3;
  localparam int LEVEL_W  = 8;
  localparam int DUR_W    = 16;
  localparam int PERIOD_W = 6;
  localparam int FADE_W   = 16;
  localparam int COUNT_W  = 6;
  localparam int DUTY_W   = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(32);
  localparam logic [FADE_W-1:0]   FADE_RST   = FADE_W'(16);

  localparam logic [LEVEL_W-1:0] LIGHT_LEVEL_MAX = LEVEL_W'(8);
  localparam logic [LEVEL_W-1:0] MOTOR_LEVEL_MAX = LEVEL_W'(16);
  localparam int FADE_FLOOR = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PWM_CLK   = 3'd0,
    CMD_SYS_TICK  = 3'd1,
    CMD_LIGHT_ON  = 3'd2,
    CMD_MOTOR_ON  = 3'd3,
    CMD_SHUTDOWN  = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PWM_PERIOD = 1'b0,
    CFG_FADE_STEP  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [LEVEL_W-1:0] level;
    logic [DUR_W-1:0]   duration;
  } item_t;

endpackage

// ===== src/bmpf_in_stage.sv =====
// input register stage holding one request ahead of the core
module bmpf_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bmpf_pkg::item_t     in_item,
  input  logic                advance,
  output logic                item_valid,
  output bmpf_pkg::item_t     item
);

  logic            valid_r, valid_nxt;
  bmpf_pkg::item_t item_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== src/bmpf_core.sv =====
// channel state, timers and result register
module bmpf_core #(
  parameter int TIMER_BITS = bmpf_pkg::TIMER_BITS_DEF,
  parameter int DUTY_BITS  = bmpf_pkg::DUTY_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bmpf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bmpf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                item_valid,
  input  bmpf_pkg::item_t                     item,
  output logic                                advance,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_light_pin,
  output logic                                out_motor_pin,
  output logic                                out_light_enabled,
  output logic                                out_motor_enabled,
  output logic [bmpf_pkg::DUTY_W-1:0]         out_light_duty,
  output logic [bmpf_pkg::DUTY_W-1:0]         out_motor_duty
);

  localparam logic [32:0] TmrMax = (33'd1 << TIMER_BITS) - 33'd1;

  // configuration
  logic [bmpf_pkg::PERIOD_W-1:0] period_r;
  logic [bmpf_pkg::FADE_W-1:0]   fade_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= bmpf_pkg::PERIOD_RST;
      fade_r   <= bmpf_pkg::FADE_RST;
    end else if (cfg_we) begin
      unique case (bmpf_pkg::cfg_idx_t'(cfg_index))
        bmpf_pkg::CFG_PWM_PERIOD: period_r <= cfg_data[bmpf_pkg::PERIOD_W-1:0];
        bmpf_pkg::CFG_FADE_STEP:  fade_r   <= cfg_data[bmpf_pkg::FADE_W-1:0];
        default: ;
      endcase
    end
  end

  // channel state
  logic [bmpf_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [DUTY_BITS-1:0]         lcmp_r, lcmp_nxt, mcmp_r, mcmp_nxt;
  logic                         lact_r, lact_nxt, mact_r, mact_nxt;
  logic [TIMER_BITS-1:0]        lrem_r, lrem_nxt, mrem_r, mrem_nxt;
  logic                         larm_r, larm_nxt, marm_r, marm_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic                         lpin_r, mpin_r, len_r, men_r;
  logic [bmpf_pkg::DUTY_W-1:0]  lduty_r, mduty_r;

  logic                         take;
  logic [bmpf_pkg::LEVEL_W-1:0] llvl, mlvl;
  logic [32:0]                  dur_ext, fade_ext;
  logic [TIMER_BITS-1:0]        dur_sat, fade_sat, lrem_dec, mrem_dec;
  logic [DUTY_BITS-1:0]         count_ext;

  assign advance = !out_valid_r || out_ready;
  assign take    = advance && item_valid;

  always_comb begin
    dur_ext  = {17'd0, item.duration};
    fade_ext = {17'd0, ((fade_r == '0) ? bmpf_pkg::FADE_W'(1) : fade_r)};
    dur_sat  = (dur_ext  > TmrMax) ? TmrMax[TIMER_BITS-1:0] : dur_ext[TIMER_BITS-1:0];
    fade_sat = (fade_ext > TmrMax) ? TmrMax[TIMER_BITS-1:0] : fade_ext[TIMER_BITS-1:0];
    lrem_dec = (lrem_r != '0) ? lrem_r - TIMER_BITS'(1) : lrem_r;
    mrem_dec = (mrem_r != '0) ? mrem_r - TIMER_BITS'(1) : mrem_r;
    llvl = (item.level > bmpf_pkg::LIGHT_LEVEL_MAX) ? bmpf_pkg::LIGHT_LEVEL_MAX : item.level;
    mlvl = (item.level > bmpf_pkg::MOTOR_LEVEL_MAX) ? bmpf_pkg::MOTOR_LEVEL_MAX : item.level;

    count_nxt = count_r;
    lcmp_nxt  = lcmp_r;
    mcmp_nxt  = mcmp_r;
    lact_nxt  = lact_r;
    mact_nxt  = mact_r;
    lrem_nxt  = lrem_r;
    mrem_nxt  = mrem_r;
    larm_nxt  = larm_r;
    marm_nxt  = marm_r;

    if (take) begin
      case (item.command)
        bmpf_pkg::CMD_PWM_CLK: begin
          if (count_r >= period_r) begin
            count_nxt = '0;
          end else begin
            count_nxt = count_r + bmpf_pkg::COUNT_W'(1);
          end
        end
        bmpf_pkg::CMD_SYS_TICK: begin
          if (larm_r) begin
            lrem_nxt = lrem_dec;
            if (lrem_dec == '0) begin
              // expiry: step the fade down or switch the light off
              if (lcmp_r > DUTY_BITS'(bmpf_pkg::FADE_FLOOR)) begin
                lcmp_nxt = lcmp_r - DUTY_BITS'(1);
                lrem_nxt = fade_sat;
                larm_nxt = 1'b1;
              end else begin
                lact_nxt = 1'b0;
                larm_nxt = 1'b0;
              end
            end
          end
          if (marm_r) begin
            mrem_nxt = mrem_dec;
            if (mrem_dec == '0) begin
              mact_nxt = 1'b0;
              marm_nxt = 1'b0;
            end
          end
        end
        bmpf_pkg::CMD_LIGHT_ON: begin
          if (llvl == '0) begin
            lact_nxt = 1'b0;
          end else begin
            lact_nxt = 1'b1;
            lcmp_nxt = DUTY_BITS'({llvl, 2'b00});
            if (item.duration != '0) begin
              lrem_nxt = dur_sat;
              larm_nxt = 1'b1;
            end
          end
        end
        bmpf_pkg::CMD_MOTOR_ON: begin
          if (mlvl == '0) begin
            mact_nxt = 1'b0;
          end else begin
            mact_nxt = 1'b1;
            mcmp_nxt = DUTY_BITS'({mlvl, 1'b0});
            if (item.duration != '0) begin
              mrem_nxt = dur_sat;
              marm_nxt = 1'b1;
            end
          end
        end
        bmpf_pkg::CMD_SHUTDOWN: begin
          lact_nxt = 1'b0;
          mact_nxt = 1'b0;
        end
        default: ;
      endcase
    end

    count_ext     = DUTY_BITS'(count_nxt);
    out_valid_nxt = advance ? item_valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      lcmp_r      <= '0;
      mcmp_r      <= '0;
      lact_r      <= 1'b0;
      mact_r      <= 1'b0;
      lrem_r      <= '0;
      mrem_r      <= '0;
      larm_r      <= 1'b0;
      marm_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      lcmp_r      <= lcmp_nxt;
      mcmp_r      <= mcmp_nxt;
      lact_r      <= lact_nxt;
      mact_r      <= mact_nxt;
      lrem_r      <= lrem_nxt;
      mrem_r      <= mrem_nxt;
      larm_r      <= larm_nxt;
      marm_r      <= marm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register, loaded with the state after the request
  always_ff @(posedge clk) begin
    if (take) begin
      lpin_r  <= lact_nxt && (count_ext < lcmp_nxt);
      mpin_r  <= mact_nxt && (count_ext < mcmp_nxt);
      len_r   <= lact_nxt;
      men_r   <= mact_nxt;
      lduty_r <= lcmp_nxt[bmpf_pkg::DUTY_W-1:0];
      mduty_r <= mcmp_nxt[bmpf_pkg::DUTY_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_light_pin     = lpin_r;
  assign out_motor_pin     = mpin_r;
  assign out_light_enabled = len_r;
  assign out_motor_enabled = men_r;
  assign out_light_duty    = lduty_r;
  assign out_motor_duty    = mduty_r;

endmodule

// ===== src/backlight_motor_pwm_fade_top.sv =====
// top level: backlight and motor pwm with one-shot fade and stop timers
// a request is held in the input register until the core advances, then its result is held in the result register
// throughput: one request per cycle while results are taken, set by the single state update in the core
// while a result waits on the output the input register takes one more request, then stalls
// synchronous active-low reset clears channel state and timers, period 32, fade step 16
module backlight_motor_pwm_fade_top #(
  parameter int TIMER_BITS = bmpf_pkg::TIMER_BITS_DEF,
  parameter int DUTY_BITS  = bmpf_pkg::DUTY_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bmpf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bmpf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bmpf_pkg::CMD_W-1:0]       in_command,
  input  logic [bmpf_pkg::LEVEL_W-1:0]     in_level,
  input  logic [bmpf_pkg::DUR_W-1:0]       in_duration,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_light_pin,
  output logic                             out_motor_pin,
  output logic                             out_light_enabled,
  output logic                             out_motor_enabled,
  output logic [bmpf_pkg::DUTY_W-1:0]      out_light_duty,
  output logic [bmpf_pkg::DUTY_W-1:0]      out_motor_duty
);

  bmpf_pkg::item_t in_item, item;
  logic            item_valid, advance;

  assign in_item = '{command: in_command, level: in_level, duration: in_duration};

  bmpf_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  bmpf_core #(
    .TIMER_BITS (TIMER_BITS),
    .DUTY_BITS  (DUTY_BITS)
  ) u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .item_valid        (item_valid),
    .item              (item),
    .advance           (advance),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_light_pin     (out_light_pin),
    .out_motor_pin     (out_motor_pin),
    .out_light_enabled (out_light_enabled),
    .out_motor_enabled (out_motor_enabled),
    .out_light_duty    (out_light_duty),
    .out_motor_duty    (out_motor_duty)
  );

endmodule

// ===== src/bmpf_checker.sv =====
// port-level checks for the pwm fade block and their bind
module bmpf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_light_pin,
  input logic                        out_motor_pin,
  input logic                        out_light_enabled,
  input logic                        out_motor_enabled,
  input logic [bmpf_pkg::DUTY_W-1:0] out_light_duty,
  input logic [bmpf_pkg::DUTY_W-1:0] out_motor_duty
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a pin can only be high on an enabled channel
  a_pin_en: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((!out_light_pin || out_light_enabled) &&
                   (!out_motor_pin || out_motor_enabled)))
    else $error("pin high on disabled channel");

  // an enabled light never shows zero duty, as the fade stops at the floor
  a_light_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_light_enabled |-> out_light_duty != '0)
    else $error("enabled light with zero duty");

  // motor duty is always twice a level
  a_motor_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_motor_duty[0] == 1'b0) &&
                  (!out_motor_enabled || out_motor_duty != '0))
    else $error("bad motor duty");

endmodule

bind backlight_motor_pwm_fade_top bmpf_checker u_bmpf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_light_pin     (out_light_pin),
  .out_motor_pin     (out_motor_pin),
  .out_light_enabled (out_light_enabled),
  .out_motor_enabled (out_motor_enabled),
  .out_light_duty    (out_light_duty),
  .out_motor_duty    (out_motor_duty)
);

// ===== bench/tb_backlight_motor_pwm_fade_top.sv =====
// testbench for the backlight and motor pwm fade block: tracking scoreboard, driver tasks, checks
`timescale 1ns / 100ps

module tb_backlight_motor_pwm_fade_top;
  import bmpf_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PRINT_CAP   = 100;
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic              light_pin;
    logic              motor_pin;
    logic              light_enabled;
    logic              motor_enabled;
    logic [DUTY_W-1:0] light_duty;
    logic [DUTY_W-1:0] motor_duty;
  } pin_state_t;

  // tracks the pwm channels and timers and holds the pin states still owed by the block
  class pwm_fade_tracker;
    logic [PERIOD_W-1:0] period;
    logic [FADE_W-1:0]   fade_step;
    logic [COUNT_W-1:0]  count;
    logic [DUTY_W-1:0]   light_cmp;
    logic [DUTY_W-1:0]   motor_cmp;
    logic [DUR_W-1:0]    light_left;
    logic [DUR_W-1:0]    motor_left;
    bit                  light_live;
    bit                  motor_live;
    bit                  light_armed;
    bit                  motor_armed;
    pin_state_t          pending_pins[$];
    int                  seen_outputs;

    function new();
      period       = PERIOD_RST;
      fade_step    = FADE_RST;
      count        = '0;
      light_cmp    = '0;
      motor_cmp    = '0;
      light_left   = '0;
      motor_left   = '0;
      light_live   = 1'b0;
      motor_live   = 1'b0;
      light_armed  = 1'b0;
      motor_armed  = 1'b0;
      seen_outputs = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PWM_PERIOD: period = data[PERIOD_W-1:0];
        CFG_FADE_STEP:  fade_step = data[FADE_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(item_t req);
      logic [LEVEL_W-1:0] lvl;
      pin_state_t         res;
      lvl = req.level;
      case (req.command)
        CMD_PWM_CLK: count = (count >= period) ? '0 : COUNT_W'(count + 1);
        CMD_SYS_TICK: begin
          if (light_armed) begin
            if (light_left != 0) light_left = light_left - 1;
            // expiry fades one step and rearms until the floor, then switches off
            if (light_left == 0) begin
              if (light_cmp > FADE_FLOOR) begin
                light_cmp  = light_cmp - 1;
                light_left = (fade_step == 0) ? DUR_W'(1) : fade_step;
              end else begin
                light_live  = 1'b0;
                light_armed = 1'b0;
              end
            end
          end
          if (motor_armed) begin
            if (motor_left != 0) motor_left = motor_left - 1;
            if (motor_left == 0) begin
              motor_live  = 1'b0;
              motor_armed = 1'b0;
            end
          end
        end
        CMD_LIGHT_ON: begin
          if (lvl > LIGHT_LEVEL_MAX) lvl = LIGHT_LEVEL_MAX;
          if (lvl == 0) begin
            light_live = 1'b0;
          end else begin
            light_live = 1'b1;
            light_cmp  = DUTY_W'(lvl * 4);
            if (req.duration != 0) begin
              light_left  = req.duration;
              light_armed = 1'b1;
            end
          end
        end
        CMD_MOTOR_ON: begin
          if (lvl > MOTOR_LEVEL_MAX) lvl = MOTOR_LEVEL_MAX;
          if (lvl == 0) begin
            motor_live = 1'b0;
          end else begin
            motor_live = 1'b1;
            motor_cmp  = DUTY_W'(lvl * 2);
            if (req.duration != 0) begin
              motor_left  = req.duration;
              motor_armed = 1'b1;
            end
          end
        end
        CMD_SHUTDOWN: begin
          light_live = 1'b0;
          motor_live = 1'b0;
        end
        default: ;
      endcase
      res.light_pin     = light_live && (count < light_cmp);
      res.motor_pin     = motor_live && (count < motor_cmp);
      res.light_enabled = light_live;
      res.motor_enabled = motor_live;
      res.light_duty    = light_cmp;
      res.motor_duty    = motor_cmp;
      pending_pins.push_back(res);
    endfunction

    // empty string when the output matches the oldest pending pin state
    function string check_output(pin_state_t got);
      pin_state_t want;
      string      diffs;
      seen_outputs++;
      if (pending_pins.size() == 0)
        return $sformatf("output %0d arrived with no request outstanding", seen_outputs);
      want  = pending_pins.pop_front();
      diffs = "";
      if (got.light_pin !== want.light_pin)
        diffs = {diffs, $sformatf(" light_pin %b want %b", got.light_pin, want.light_pin)};
      if (got.motor_pin !== want.motor_pin)
        diffs = {diffs, $sformatf(" motor_pin %b want %b", got.motor_pin, want.motor_pin)};
      if (got.light_enabled !== want.light_enabled)
        diffs = {diffs, $sformatf(" light_enabled %b want %b",
                                  got.light_enabled, want.light_enabled)};
      if (got.motor_enabled !== want.motor_enabled)
        diffs = {diffs, $sformatf(" motor_enabled %b want %b",
                                  got.motor_enabled, want.motor_enabled)};
      if (got.light_duty !== want.light_duty)
        diffs = {diffs, $sformatf(" light_duty %0d want %0d", got.light_duty, want.light_duty)};
      if (got.motor_duty !== want.motor_duty)
        diffs = {diffs, $sformatf(" motor_duty %0d want %0d", got.motor_duty, want.motor_duty)};
      if (diffs == "") return "";
      return $sformatf("output %0d:%s", seen_outputs, diffs);
    endfunction
  endclass

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = CFG_PWM_PERIOD;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      in_command  = CMD_PWM_CLK;
  logic [LEVEL_W-1:0]    in_level    = '0;
  logic [DUR_W-1:0]      in_duration = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic                  out_light_pin;
  logic                  out_motor_pin;
  logic                  out_light_enabled;
  logic                  out_motor_enabled;
  logic [DUTY_W-1:0]     out_light_duty;
  logic [DUTY_W-1:0]     out_motor_duty;

  pwm_fade_tracker tracker;
  int              mismatches   = 0;
  int              quiet_cycles = 0;
  int              in_calm      = 0;
  int              out_calm     = 0;
  string           verdict;
  int              phase;
  int              useful;
  int              on_pct;
  logic [PERIOD_W-1:0] period_val;
  logic [FADE_W-1:0]   step_val;
  item_t           req;

  backlight_motor_pwm_fade_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_level          (in_level),
    .in_duration       (in_duration),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_light_pin     (out_light_pin),
    .out_motor_pin     (out_motor_pin),
    .out_light_enabled (out_light_enabled),
    .out_motor_enabled (out_motor_enabled),
    .out_light_duty    (out_light_duty),
    .out_motor_duty    (out_motor_duty)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // mostly uniform waits, with the odd run of back-to-back requests
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) calm = $urandom_range(20, 80);
    return $urandom_range(0, 17);
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [LEVEL_W-1:0] lvl,
                              input logic [DUR_W-1:0] dur);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_level    <= lvl;
    in_duration <= dur;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_pins.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_config(input logic [PERIOD_W-1:0] per, input logic [FADE_W-1:0] step);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PWM_PERIOD;
    // spare upper bits of the period write carry noise
    cfg_data  <= {(CFG_DATA_W-PERIOD_W)'($urandom), per};
    @(posedge clk);
    cfg_index <= CFG_FADE_STEP;
    cfg_data  <= step;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic item_t next_request(input int on_share);
    int    r;
    item_t pick;
    r = $urandom_range(0, 99);
    if (r < on_share / 2)
      pick.command = CMD_LIGHT_ON;
    else if (r < on_share)
      pick.command = CMD_MOTOR_ON;
    else if (r < on_share + 3)
      pick.command = CMD_SHUTDOWN;
    else if (r < on_share + 5)
      pick.command = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    else if (r < on_share + 5 + (95 - on_share) / 2)
      pick.command = CMD_PWM_CLK;
    else
      pick.command = CMD_SYS_TICK;
    pick.level = ($urandom_range(0, 2) == 0) ? LEVEL_W'($urandom) :
                                                LEVEL_W'($urandom_range(0, 17));
    r = $urandom_range(0, 19);
    if (r < 6)
      pick.duration = '0;
    else if (r < 17)
      pick.duration = DUR_W'($urandom_range(1, 24));
    else
      pick.duration = DUR_W'($urandom);
    return pick;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) tracker.write_reg(cfg_idx_t'(cfg_index), cfg_data);
      if (in_valid && in_ready)
        tracker.note_request(item_t'{in_command, in_level, in_duration});
      if (out_valid && out_ready) begin
        verdict = tracker.check_output(pin_state_t'{out_light_pin, out_motor_pin,
                                                    out_light_enabled, out_motor_enabled,
                                                    out_light_duty, out_motor_duty});
        if (verdict != "") report_mismatch(verdict);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
        $display("backlight_motor_pwm_fade_top verification failed");
        $finish;
      end
    end
  end

  initial begin : result_side
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    tracker = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: unused codes, clamps, disables, shutdown over a live timer, rearm, expiries
    send_request(CMD_UNUSED_LO, 8'hFF, 16'hFFFF);
    send_request(CMD_W'(CMD_UNUSED_LO + 1), 8'h00, 16'h0000);
    send_request(CMD_UNUSED_HI, 8'hA5, 16'h5A5A);
    send_request(CMD_LIGHT_ON, 8'hFF, 16'h0000);
    send_request(CMD_MOTOR_ON, 8'hFF, 16'h0000);
    send_request(CMD_PWM_CLK, 8'h00, 16'h0000);
    send_request(CMD_MOTOR_ON, 8'd17, 16'h0000);
    send_request(CMD_MOTOR_ON, 8'd1, 16'h0000);
    send_request(CMD_PWM_CLK, 8'h5A, 16'hA5A5);
    send_request(CMD_PWM_CLK, 8'h00, 16'h0000);
    send_request(CMD_LIGHT_ON, 8'd0, 16'hFFFF);
    send_request(CMD_MOTOR_ON, 8'd0, 16'hFFFF);
    send_request(CMD_LIGHT_ON, 8'd1, 16'd2);
    send_request(CMD_SHUTDOWN, 8'hFF, 16'hFFFF);
    send_request(CMD_SYS_TICK, 8'h00, 16'h0000);
    send_request(CMD_SYS_TICK, 8'hFF, 16'hFFFF);
    send_request(CMD_MOTOR_ON, 8'd16, 16'hFFFF);
    send_request(CMD_MOTOR_ON, 8'd3, 16'd1);
    send_request(CMD_SYS_TICK, 8'h00, 16'h0000);
    send_request(CMD_LIGHT_ON, 8'd8, 16'd1);
    send_request(CMD_SYS_TICK, 8'h00, 16'h0000);
    send_request(CMD_PWM_CLK, 8'h00, 16'h0000);

    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          period_val = 6'd63;
          step_val   = 16'd1;
          on_pct     = 20;
        end
        1: begin
          period_val = 6'd1;
          step_val   = 16'd3;
          on_pct     = 6;
        end
        2: begin
          // a fade step of zero behaves as one tick
          period_val = PERIOD_W'($urandom_range(1, 63));
          step_val   = 16'd0;
          on_pct     = 4;
        end
        3: begin
          period_val = PERIOD_W'($urandom_range(1, 63));
          step_val   = 16'hFFFF;
          on_pct     = 20;
        end
        4: begin
          period_val = 6'd0;
          step_val   = 16'd2;
          on_pct     = 10;
        end
        default: begin
          period_val = PERIOD_W'($urandom_range(1, 63));
          step_val   = FADE_W'($urandom_range(1, 12));
          on_pct     = 6;
        end
      endcase
      wait_idle(4);
      set_config(period_val, step_val);
      useful = 0;
      while (useful < 275) begin
        req = next_request(on_pct);
        send_request(req.command, req.level, req.duration);
        if (req.command <= CMD_SHUTDOWN) useful++;
      end
    end

    wait_idle(10);
    if (mismatches == 0 && tracker.pending_pins.size() == 0) begin
      $display("backlight_motor_pwm_fade_top verification clean");
    end else begin
      $display("backlight_motor_pwm_fade_top verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/bmpf_pkg.sv
src/bmpf_in_stage.sv
src/bmpf_core.sv
src/backlight_motor_pwm_fade_top.sv
src/bmpf_checker.sv
bench/tb_backlight_motor_pwm_fade_top.sv
